### rtl/core/slle_pkg.sv
package slle_pkg;

	// Bound on the line length; a line holds at most LINE_BYTES-1 characters.
	localparam int LINE_BYTES = 256;
	localparam int CNT_W      = $clog2(LINE_BYTES);
	// Number of leading characters that take part in the login compare.
	localparam int CMP_CHARS  = 8;
	localparam int CMP_IDX_W  = $clog2(CMP_CHARS);

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_DEL   = 8'd127;

	localparam logic [1:0] REG_USER_CHARS = 2'd0;
	localparam logic [1:0] REG_USER_LEN   = 2'd1;
	localparam logic [1:0] REG_PASS_CHARS = 2'd2;
	localparam logic [1:0] REG_PASS_LEN   = 2'd3;

	localparam logic [63:0] RST_USER_CHARS = 64'd7954873642686770785;
	localparam logic [3:0]  RST_USER_LEN   = 4'd8;
	localparam logic [63:0] RST_PASS_CHARS = 64'd228509037105;
	localparam logic [3:0]  RST_PASS_LEN   = 4'd5;

	typedef enum logic [1:0] {
		OP_PRINT,
		OP_ERASE,
		OP_ENTER
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [63:0] user_chars;
		logic [3:0]  user_len;
		logic [63:0] pass_chars;
		logic [3:0]  pass_len;
	} cfg_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} bk_state_t;

	typedef enum logic [1:0] {
		SEQ_CHAR,
		SEQ_NEWLINE,
		SEQ_ERASE
	} seq_t;

endpackage

### rtl/core/serial_login_line_editor.sv
// Serial login line editor. Received bytes enter on the rx channel and edit a
// user name line and then a password line; echo bytes leave on the tx channel,
// one transaction per echo byte, with last marking the final echo of a byte and
// verdict_valid and granted riding on the carriage return that ends the password
// line. Printable bytes echo themselves (or '*' in the password), erase bytes
// echo backspace, space, backspace when the line is not empty, and line ends
// echo LF then CR. Bytes that edit nothing produce no transaction at all.
// Timing: the front classifier takes one rx transaction per cycle while the
// two-entry command queue has room, and drops meaningless bytes at once. The
// back sequencer takes a command from the queue, emits its echo bytes in order
// and takes no further command until the last echo is loaded; the tx output
// register sets the pace when the far side stalls. The expected strings and
// lengths sit in four 64-bit APB registers at byte addresses 0, 8, 16 and 24;
// only bits 3:0 of a length are stored, and lengths above eight count as
// eight. Write them only while the editor is idle.
module serial_login_line_editor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        tx_valid,
	input  logic        tx_ready,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic        verdict_valid,
	output logic        granted
);
	import slle_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// Configuration registers. Register index comes from the 8-byte slot address.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.user_chars <= RST_USER_CHARS;
			cfg_q.user_len   <= RST_USER_LEN;
			cfg_q.pass_chars <= RST_PASS_CHARS;
			cfg_q.pass_len   <= RST_PASS_LEN;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_USER_CHARS: cfg_q.user_chars <= pwdata;
				REG_USER_LEN:   cfg_q.user_len   <= pwdata[3:0];
				REG_PASS_CHARS: cfg_q.pass_chars <= pwdata;
				REG_PASS_LEN:   cfg_q.pass_len   <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_USER_CHARS: prdata = cfg_q.user_chars;
			REG_USER_LEN:   prdata = {60'd0, cfg_q.user_len};
			REG_PASS_CHARS: prdata = cfg_q.pass_chars;
			REG_PASS_LEN:   prdata = {60'd0, cfg_q.pass_len};
			default:        prdata = 64'd0;
		endcase
	end

	// The front classifies bytes into commands; the queue lets it keep taking
	// bytes while the back is busy echoing or stalled by tx_ready.
	slle_front u_front (
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	slle_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// The back owns the line state, runs the compare and emits the echoes.
	slle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.tx_valid      (tx_valid),
		.tx_ready      (tx_ready),
		.tx_byte       (tx_byte),
		.last          (last),
		.verdict_valid (verdict_valid),
		.granted       (granted)
	);

	// A verdict only ever rides on the closing carriage return.
	a_verdict_on_cr: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && verdict_valid |-> last && (tx_byte == CH_CR))
		else $error("verdict outside the final carriage return");

	// Access can only be granted together with a verdict.
	a_grant_needs_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && granted |-> verdict_valid)
		else $error("granted without verdict_valid");

	// A line feed is never the final echo of a byte.
	a_lf_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (tx_byte == CH_LF) && !pop |-> !last)
		else $error("line feed marked as last echo");

	// The queue never takes a command while it is full.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command pushed into a full queue");

endmodule

### rtl/core/slle_front.sv
module slle_front (
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	input  logic              q_full,
	output logic              push,
	output slle_pkg::cmd_t    push_cmd
);
	import slle_pkg::*;

	logic keep;

	assign rx_ready = !q_full;

	// Sort each byte into an editing command; bytes with no meaning are dropped here.
	always_comb begin
		keep          = 1'b1;
		push_cmd.op   = OP_PRINT;
		push_cmd.data = rx_byte;
		unique case (rx_byte) inside
			CH_LF, CH_CR: begin
				push_cmd.op = OP_ENTER;
			end
			CH_BS, CH_DEL: begin
				push_cmd.op = OP_ERASE;
			end
			[CH_SPACE:CH_TILDE]: begin
				push_cmd.op = OP_PRINT;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = rx_valid && rx_ready && keep;

endmodule

### rtl/core/slle_cmd_queue.sv
module slle_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slle_pkg::cmd_t push_cmd,
	input  logic           pop,
	output slle_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	import slle_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);

endmodule

### rtl/core/slle_back.sv
module slle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  slle_pkg::cfg_t cfg,
	input  slle_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	output logic           tx_valid,
	input  logic           tx_ready,
	output logic [7:0]     tx_byte,
	output logic           last,
	output logic           verdict_valid,
	output logic           granted
);
	import slle_pkg::*;

	bk_state_t state_q, state_d;
	seq_t      seq_q;
	logic [1:0] step_q;
	logic [7:0] echo_q;
	logic       vv_q;
	logic       ok_q;

	logic [CNT_W-1:0] char_count_q;
	logic [CNT_W-1:0] user_count_q;
	logic             field_q;
	// Only the leading characters can decide a match, so only they are kept.
	logic [CMP_CHARS-1:0][7:0] user_sh_q;
	logic [CMP_CHARS-1:0][7:0] pass_sh_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_vv_q;
	logic       out_gr_q;

	logic       start;
	logic       load;
	logic       res_last;
	logic       res_vv;
	logic [7:0] res_byte;
	logic       match;

	function automatic logic line_match(input logic [CMP_CHARS-1:0][7:0] line,
	                                    input logic [CNT_W-1:0] count,
	                                    input logic [63:0] chars,
	                                    input logic [3:0] len_raw);
		logic [3:0] len;
		logic       ok;
		len = (len_raw > 4'd8) ? 4'd8 : len_raw;
		ok  = (count == CNT_W'(len));
		for (int i = 0; i < CMP_CHARS; i++) begin
			if ((i < int'(len)) && (line[i] != chars[8*i +: 8])) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	assign match = line_match(user_sh_q, user_count_q, cfg.user_chars, cfg.user_len)
	            && line_match(pass_sh_q, char_count_q, cfg.pass_chars, cfg.pass_len);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (load && res_last) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = !empty;
			end
			BK_EMIT: begin
				load = !out_valid_q || tx_ready;
			end
			default: begin
			end
		endcase
	end

	// A popped command starts an echo sequence unless it changes nothing.
	always_comb begin
		start = 1'b0;
		if (pop) begin
			case (head.op)
				OP_ENTER: start = 1'b1;
				OP_ERASE: start = (char_count_q != '0);
				OP_PRINT: start = (char_count_q < CNT_W'(LINE_BYTES - 1));
				default:  start = 1'b0;
			endcase
		end
	end

	always_comb begin
		res_byte = echo_q;
		res_last = 1'b1;
		res_vv   = 1'b0;
		case (seq_q)
			SEQ_NEWLINE: begin
				res_byte = (step_q == 2'd0) ? CH_LF : CH_CR;
				res_last = (step_q != 2'd0);
				res_vv   = (step_q != 2'd0) && vv_q;
			end
			SEQ_ERASE: begin
				res_byte = (step_q == 2'd1) ? CH_SPACE : CH_BS;
				res_last = (step_q == 2'd2);
			end
			default: begin
				res_byte = echo_q;
				res_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			step_q       <= 2'd0;
			char_count_q <= '0;
			user_count_q <= '0;
			field_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				step_q <= 2'd0;
			end else if (load) begin
				step_q <= step_q + 2'd1;
			end
			if (pop) begin
				case (head.op)
					OP_ENTER: begin
						if (!field_q) begin
							user_count_q <= char_count_q;
						end
						field_q      <= !field_q;
						char_count_q <= '0;
					end
					OP_ERASE: begin
						if (start) begin
							char_count_q <= char_count_q - CNT_W'(1);
						end
					end
					default: begin
						if (start) begin
							char_count_q <= char_count_q + CNT_W'(1);
						end
					end
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tx_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			vv_q <= field_q;
			ok_q <= match;
			echo_q <= field_q ? CH_STAR : head.data;
			case (head.op)
				OP_ENTER: seq_q <= SEQ_NEWLINE;
				OP_ERASE: seq_q <= SEQ_ERASE;
				default:  seq_q <= SEQ_CHAR;
			endcase
			if (head.op == OP_PRINT && start && char_count_q < CNT_W'(CMP_CHARS)) begin
				if (field_q) begin
					pass_sh_q[char_count_q[CMP_IDX_W-1:0]] <= head.data;
				end else begin
					user_sh_q[char_count_q[CMP_IDX_W-1:0]] <= head.data;
				end
			end
		end
		if (load) begin
			out_byte_q <= res_byte;
			out_last_q <= res_last;
			out_vv_q   <= res_vv;
			out_gr_q   <= res_vv && ok_q;
		end
	end

	assign tx_valid      = out_valid_q;
	assign tx_byte       = out_byte_q;
	assign last          = out_last_q;
	assign verdict_valid = out_vv_q;
	assign granted       = out_gr_q;

endmodule
